[hdl/ir_edge_pulse_space_recorder_core_macros.svh]
// ---------------------------------------------------------------------------
// IR edge recorder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef IR_EDGE_PULSE_SPACE_RECORDER_CORE_MACROS_SVH
`define IR_EDGE_PULSE_SPACE_RECORDER_CORE_MACROS_SVH

// property holds at every edge outside reset
`define IR_EPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition at one edge implies a result at the next
`define IR_EPS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/ir_eps_pkg.sv]
// ---------------------------------------------------------------------------
// IR edge recorder package
// Widths, register map, reset values and shared types.
// ---------------------------------------------------------------------------
package ir_eps_pkg;

  // duration width and saturation value
  localparam int DURATION_BITS = 24;
  typedef logic [DURATION_BITS-1:0] dur_t;
  localparam dur_t DUR_MAX = '1;

  localparam int USEC_PER_SEC = 1000000;

  // register field widths
  localparam int THR_BITS = 24;
  localparam int LGS_BITS = 6;
  typedef logic [THR_BITS-1:0] thr_t;
  typedef logic [LGS_BITS-1:0] lgs_t;

  // timestamp widths
  localparam int SEC_BITS = 32;
  localparam int US_BITS  = 20;

  // APB register map (word addresses)
  localparam int ADDR_BITS = 4;
  typedef enum logic [1:0] {
    REG_ACTIVE_LOW       = 2'd0,
    REG_PULSE_FLUSH_MIN  = 2'd1,
    REG_GAP_HOLD_MIN     = 2'd2,
    REG_LONG_GAP_SECONDS = 2'd3
  } reg_index_t;

  // register reset values
  localparam logic RST_ACTIVE_LOW       = 1'b1;
  localparam thr_t RST_PULSE_FLUSH_MIN  = THR_BITS'(250);
  localparam thr_t RST_GAP_HOLD_MIN     = THR_BITS'(20000);
  localparam lgs_t RST_LONG_GAP_SECONDS = LGS_BITS'(15);

  // input operation codes
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_START = 1'b1;

  // configuration bundle
  typedef struct packed {
    logic active_low;
    thr_t pulse_flush_min;
    thr_t gap_hold_min;
    lgs_t long_gap_seconds;
  } cfg_t;

  // measured interval
  typedef struct packed {
    dur_t dur;
    logic pulse;
  } interval_t;

  // one result word
  typedef struct packed {
    dur_t dur;
    logic is_pulse;
    logic last;
  } result_t;

  // up to three results from one item
  typedef struct packed {
    logic [1:0]       n;
    result_t [2:0]    e;
  } res_set_t;

  // saturating add of two durations
  function automatic dur_t sat_add(dur_t a, dur_t b);
    logic [DURATION_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DURATION_BITS] ? DUR_MAX : s[DURATION_BITS-1:0];
  endfunction

endpackage

[hdl/ir_eps_regs.sv]
// ---------------------------------------------------------------------------
// IR edge recorder configuration registers
// APB-style write/read port holding polarity, thresholds and gap limit.
// ---------------------------------------------------------------------------
module ir_eps_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ir_eps_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output ir_eps_pkg::cfg_t               cfg
);
  import ir_eps_pkg::*;

  logic       wr;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low       <= RST_ACTIVE_LOW;
      cfg.pulse_flush_min  <= RST_PULSE_FLUSH_MIN;
      cfg.gap_hold_min     <= RST_GAP_HOLD_MIN;
      cfg.long_gap_seconds <= RST_LONG_GAP_SECONDS;
    end else if (wr) begin
      case (idx)
        REG_ACTIVE_LOW:       cfg.active_low       <= pwdata[0];
        REG_PULSE_FLUSH_MIN:  cfg.pulse_flush_min  <= pwdata[THR_BITS-1:0];
        REG_GAP_HOLD_MIN:     cfg.gap_hold_min     <= pwdata[THR_BITS-1:0];
        REG_LONG_GAP_SECONDS: cfg.long_gap_seconds <= pwdata[LGS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ACTIVE_LOW:       prdata = 32'(cfg.active_low);
      REG_PULSE_FLUSH_MIN:  prdata = 32'(cfg.pulse_flush_min);
      REG_GAP_HOLD_MIN:     prdata = 32'(cfg.gap_hold_min);
      REG_LONG_GAP_SECONDS: prdata = 32'(cfg.long_gap_seconds);
      default:              prdata = '0;
    endcase
  end

endmodule

[hdl/ir_eps_interval.sv]
// ---------------------------------------------------------------------------
// IR edge recorder interval timer
// Holds the previous edge time and polarity; measures and classifies the
// interval up to the current edge.
// ---------------------------------------------------------------------------
module ir_eps_interval (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic                            operation,
  input  logic                            pin_level,
  input  logic [ir_eps_pkg::SEC_BITS-1:0] stamp_seconds,
  input  logic [ir_eps_pkg::US_BITS-1:0]  stamp_micros,
  input  ir_eps_pkg::cfg_t                cfg,
  output ir_eps_pkg::interval_t           iv
);
  import ir_eps_pkg::*;

  localparam int P_BITS = LGS_BITS + US_BITS;
  localparam int V_BITS = ((DURATION_BITS > P_BITS) ? DURATION_BITS : P_BITS) + 2;

  logic [SEC_BITS-1:0] prev_seconds;
  logic [US_BITS-1:0]  prev_micros;
  logic                polarity;
  logic                polarity_next;

  logic                backwards;
  logic                long_gap;
  logic [SEC_BITS-1:0] sec_diff;
  logic [P_BITS-1:0]   prod;
  logic signed [V_BITS-1:0] v;
  logic [V_BITS-2:0]   vmag;

  // ordering and gap checks
  assign backwards = (stamp_seconds < prev_seconds) ||
                     ((stamp_seconds == prev_seconds) && (stamp_micros < prev_micros));
  assign sec_diff  = stamp_seconds - prev_seconds;
  assign long_gap  = !backwards && (sec_diff > SEC_BITS'(cfg.long_gap_seconds));

  // a long gap that reads as a pulse flips polarity so it becomes a space
  assign polarity_next = (long_gap && (pin_level == polarity)) ? ~polarity : polarity;

  // microsecond difference; seconds difference is at most 63 here
  assign prod = P_BITS'(sec_diff[LGS_BITS-1:0]) * P_BITS'(USEC_PER_SEC);
  assign v    = $signed(V_BITS'(prod)) + $signed(V_BITS'(stamp_micros))
              - $signed(V_BITS'(prev_micros));
  assign vmag = v[V_BITS-2:0];

  always_comb begin
    if (backwards || long_gap) begin
      iv.dur = DUR_MAX;
    end else if (v[V_BITS-1]) begin
      iv.dur = '0;
    end else if (vmag > (V_BITS-1)'(DUR_MAX)) begin
      iv.dur = DUR_MAX;
    end else begin
      iv.dur = vmag[DURATION_BITS-1:0];
    end
    iv.pulse = (pin_level == polarity_next);
  end

  // previous edge and polarity
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_seconds <= '0;
      prev_micros  <= '0;
      polarity     <= 1'b1;
    end else if (fire) begin
      prev_seconds <= stamp_seconds;
      prev_micros  <= stamp_micros;
      polarity     <= (operation == OP_START) ? cfg.active_low : polarity_next;
    end
  end

endmodule

[hdl/ir_eps_filter.sv]
// ---------------------------------------------------------------------------
// IR edge recorder noise filter
// Holds long spaces, folds short pulses into them and emits the result
// words caused by one edge.
// ---------------------------------------------------------------------------
module ir_eps_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  is_edge,
  input  ir_eps_pkg::interval_t iv,
  input  ir_eps_pkg::cfg_t      cfg,
  output ir_eps_pkg::res_set_t  res
);
  import ir_eps_pkg::*;

  localparam int CMP_BITS = (DURATION_BITS > THR_BITS) ? DURATION_BITS : THR_BITS;

  dur_t held_space, held_space_next;
  dur_t held_pulse, held_pulse_next;
  logic holding, holding_next;

  dur_t hp_sum;
  dur_t merged;
  logic big_space;
  logic flush_pulse;

  function automatic logic above(dur_t a, thr_t b);
    return CMP_BITS'(a) > CMP_BITS'(b);
  endfunction

  assign hp_sum      = sat_add(held_pulse, iv.dur);
  assign merged      = sat_add(sat_add(held_space, held_pulse), iv.dur);
  assign big_space   = above(iv.dur, cfg.gap_hold_min);
  assign flush_pulse = above(hp_sum, cfg.pulse_flush_min);

  // filter decision
  always_comb begin
    held_space_next = held_space;
    held_pulse_next = held_pulse;
    holding_next    = holding;
    res             = '0;
    if (is_edge) begin
      if (holding && iv.pulse) begin
        held_pulse_next = hp_sum;
        if (flush_pulse) begin
          res.e[0]        = '{dur: held_space, is_pulse: 1'b0, last: 1'b0};
          res.e[1]        = '{dur: hp_sum,     is_pulse: 1'b1, last: 1'b1};
          res.n           = 2'd2;
          holding_next    = 1'b0;
          held_pulse_next = '0;
        end
      end else if (!iv.pulse) begin
        if (!holding) begin
          if (big_space) begin
            held_space_next = iv.dur;
            holding_next    = 1'b1;
          end else begin
            res.e[0] = '{dur: iv.dur, is_pulse: 1'b0, last: 1'b1};
            res.n    = 2'd1;
          end
        end else if (big_space) begin
          held_space_next = merged;
          held_pulse_next = '0;
        end else begin
          res.e[0]        = '{dur: held_space, is_pulse: 1'b0, last: 1'b0};
          res.e[1]        = '{dur: held_pulse, is_pulse: 1'b1, last: 1'b0};
          res.e[2]        = '{dur: iv.dur,     is_pulse: 1'b0, last: 1'b1};
          res.n           = 2'd3;
          holding_next    = 1'b0;
          held_pulse_next = '0;
        end
      end else begin
        res.e[0] = '{dur: iv.dur, is_pulse: 1'b1, last: 1'b1};
        res.n    = 2'd1;
      end
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_space <= '0;
      held_pulse <= '0;
      holding    <= 1'b0;
    end else if (fire) begin
      held_space <= held_space_next;
      held_pulse <= held_pulse_next;
      holding    <= holding_next;
    end
  end

endmodule

[hdl/ir_eps_outq.sv]
// ---------------------------------------------------------------------------
// IR edge recorder result buffer
// Three-word shift buffer that hands result words out one per handshake.
// ---------------------------------------------------------------------------
module ir_eps_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ir_eps_pkg::res_set_t  res,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ir_eps_pkg::result_t   head
);
  import ir_eps_pkg::*;
  `include "ir_edge_pulse_space_recorder_core_macros.svh"

  result_t [2:0] slot;
  logic [1:0]    cnt;
  logic          take;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && out_ready;
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign head      = slot[0];

  // word count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.n;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  // payload: reload or shift towards the head
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= res.e;
    end else if (take) begin
      slot <= {result_t'('0), slot[2:1]};
    end
  end

  `IR_EPS_ASSERT(a_single_is_last, (cnt == 2'd1) |-> slot[0].last, "lone word lacks last")
  `IR_EPS_ASSERT(a_multi_not_last, (cnt > 2'd1) |-> !slot[0].last, "last set too early")
  `IR_EPS_ASSERT(a_load_drained, load |-> can_load, "load into undrained buffer")
  `IR_EPS_ASSERT_NEXT(a_shift_count, take && !load && cnt == 2'd3, cnt == 2'd2, "bad shift")

endmodule

[hdl/ir_edge_pulse_space_recorder_core.sv]
// ---------------------------------------------------------------------------
// IR edge pulse/space recorder core
// Turns timestamped receiver edges into pulse and space durations.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one edge or start word:
//    operation, pin_level, stamp_seconds, stamp_micros.
//  - Output channel (out_valid/out_ready) gives zero to three result words
//    per input word (duration, is_pulse, last); last marks the final one.
//  - A start word latches its time and loads polarity from active_low; it
//    gives no result. An edge word measures the time since the previous edge or start word.
//  - An accepted word is registered in the input register, then evaluated
//    into the result buffer once it can load; the buffer shows the results.
//  - Throughput: one input word per cycle while each gives at most one
//    result and the receiver is ready; a word giving more results holds
//    the buffer until its last is taken, one output word per handshake.
//  - A stalled receiver holds the head word; one further input word is taken
//    into the input register meanwhile, then in_ready drops.
//  - Configuration via the APB-style port, written only while idle.
//  - Reset (rst, synchronous) empties both registers, clears the filter and
//    timestamp, sets polarity to one and restores register defaults.
// ---------------------------------------------------------------------------
module ir_edge_pulse_space_recorder_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ir_eps_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic                              pin_level,
  input  logic [ir_eps_pkg::SEC_BITS-1:0]   stamp_seconds,
  input  logic [ir_eps_pkg::US_BITS-1:0]    stamp_micros,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ir_eps_pkg::DURATION_BITS-1:0] duration,
  output logic                              is_pulse,
  output logic                              last
);
  import ir_eps_pkg::*;

  cfg_t      cfg;
  interval_t iv;
  res_set_t  res;
  result_t   head;

  logic                ir_valid;
  logic                ir_op;
  logic                ir_pin;
  logic [SEC_BITS-1:0] ir_sec;
  logic [US_BITS-1:0]  ir_us;

  logic in_take;
  logic can_load;
  logic fire;

  assign in_take  = in_valid && in_ready;
  assign fire     = ir_valid && can_load;
  assign in_ready = !ir_valid || fire;

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_take) begin
      ir_valid <= 1'b1;
    end else if (fire) begin
      ir_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_op  <= operation;
      ir_pin <= pin_level;
      ir_sec <= stamp_seconds;
      ir_us  <= stamp_micros;
    end
  end

  ir_eps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ir_eps_interval u_interval (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .operation     (ir_op),
    .pin_level     (ir_pin),
    .stamp_seconds (ir_sec),
    .stamp_micros  (ir_us),
    .cfg           (cfg),
    .iv            (iv)
  );

  ir_eps_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .is_edge (ir_op == OP_EDGE),
    .iv      (iv),
    .cfg     (cfg),
    .res     (res)
  );

  ir_eps_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign duration = head.dur;
  assign is_pulse = head.is_pulse;
  assign last     = head.last;

endmodule

[bench/ir_eps_interval_checker.sv]
// ---------------------------------------------------------------------------
// IR edge recorder interval checker
// Watches the register port and both word channels of the recorder core,
// predicts the pulse/space words each accepted input word gives, and
// compares every accepted output word with the oldest prediction.
// ---------------------------------------------------------------------------
module ir_eps_interval_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ir_eps_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  input  logic                                 pready,
  // input channel
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 operation,
  input  logic                                 pin_level,
  input  logic [ir_eps_pkg::SEC_BITS-1:0]      stamp_seconds,
  input  logic [ir_eps_pkg::US_BITS-1:0]       stamp_micros,
  // output channel
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [ir_eps_pkg::DURATION_BITS-1:0] duration,
  input  logic                                 is_pulse,
  input  logic                                 last,
  // status towards the bench top
  output int                                   pending,
  output int                                   errors,
  output int                                   compared
);
  import ir_eps_pkg::*;

  // register copy and filter state of the predictor
  cfg_t                  cfg;
  logic [SEC_BITS-1:0]   edge_sec;
  logic [US_BITS-1:0]    edge_us;
  logic                  mark_level;
  dur_t                  held_gap;
  dur_t                  held_mark;
  logic                  merging;

  // predicted pulse/space words, oldest first
  result_t interval_q[$];

  int fail_count = 0;
  int match_count = 0;
  int backlog = 0;

  assign pending  = backlog;
  assign errors   = fail_count;
  assign compared = match_count;

  // sum of two durations, clamped at the top value
  function automatic dur_t clamp_sum(dur_t a, dur_t b);
    logic [DURATION_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, DUR_MAX}) return DUR_MAX;
    return s[DURATION_BITS-1:0];
  endfunction

  task automatic queue_interval(input dur_t d, input logic p, input logic l);
    result_t r;
    r.dur      = d;
    r.is_pulse = p;
    r.last     = l;
    interval_q.push_back(r);
  endtask

  // one edge word: measure, classify, then run the noise filter
  task automatic predict_edge(input logic pin, input logic [SEC_BITS-1:0] sec,
                              input logic [US_BITS-1:0] us);
    dur_t                d;
    logic                mark;
    logic [SEC_BITS-1:0] dsec;
    longint              span;
    dsec = sec - edge_sec;
    if (sec < edge_sec || (sec == edge_sec && us < edge_us)) begin
      // clock ran backwards
      d = DUR_MAX;
    end else if (dsec > SEC_BITS'(cfg.long_gap_seconds)) begin
      // long gap: never reported as a pulse
      d = DUR_MAX;
      if (pin == mark_level) mark_level = ~mark_level;
    end else begin
      span = longint'(dsec) * USEC_PER_SEC + longint'(us) - longint'(edge_us);
      if (span < 0)                    d = '0;
      else if (span > longint'(DUR_MAX)) d = DUR_MAX;
      else                             d = dur_t'(span);
    end
    mark     = (pin == mark_level);
    edge_sec = sec;
    edge_us  = us;

    if (merging && mark) begin
      held_mark = clamp_sum(held_mark, d);
      if (held_mark > cfg.pulse_flush_min) begin
        queue_interval(held_gap, 1'b0, 1'b0);
        queue_interval(held_mark, 1'b1, 1'b1);
        merging   = 1'b0;
        held_mark = '0;
      end
    end else if (!mark) begin
      if (!merging) begin
        if (d > cfg.gap_hold_min) begin
          held_gap = d;
          merging  = 1'b1;
        end else begin
          queue_interval(d, 1'b0, 1'b1);
        end
      end else if (d > cfg.gap_hold_min) begin
        // another long space folds in, with any short pulses since
        held_gap  = clamp_sum(clamp_sum(held_gap, held_mark), d);
        held_mark = '0;
      end else begin
        // short space ends the hold
        queue_interval(held_gap, 1'b0, 1'b0);
        queue_interval(held_mark, 1'b1, 1'b0);
        queue_interval(d, 1'b0, 1'b1);
        merging   = 1'b0;
        held_mark = '0;
      end
    end else begin
      queue_interval(d, 1'b1, 1'b1);
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg.active_low       = RST_ACTIVE_LOW;
      cfg.pulse_flush_min  = RST_PULSE_FLUSH_MIN;
      cfg.gap_hold_min     = RST_GAP_HOLD_MIN;
      cfg.long_gap_seconds = RST_LONG_GAP_SECONDS;
      edge_sec   = '0;
      edge_us    = '0;
      mark_level = 1'b1;
      held_gap   = '0;
      held_mark  = '0;
      merging    = 1'b0;
      interval_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[ADDR_BITS-1:2]))
          REG_ACTIVE_LOW:       cfg.active_low       = pwdata[0];
          REG_PULSE_FLUSH_MIN:  cfg.pulse_flush_min  = pwdata[THR_BITS-1:0];
          REG_GAP_HOLD_MIN:     cfg.gap_hold_min     = pwdata[THR_BITS-1:0];
          REG_LONG_GAP_SECONDS: cfg.long_gap_seconds = pwdata[LGS_BITS-1:0];
          default: ;
        endcase
      end

      // output words against the oldest prediction
      if (out_valid && out_ready) begin
        if (interval_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: dur=%0d pulse=%0b last=%0b",
                     duration, is_pulse, last);
          fail_count++;
        end else begin
          want = interval_q.pop_front();
          match_count++;
          if (duration !== want.dur || is_pulse !== want.is_pulse ||
              last !== want.last) begin
            if (fail_count < 10)
              $display("result word %0d: expected dur=%0d pulse=%0b last=%0b, got dur=%0d pulse=%0b last=%0b",
                       match_count, want.dur, want.is_pulse, want.last,
                       duration, is_pulse, last);
            fail_count++;
          end
        end
      end

      // input words
      if (in_valid && in_ready) begin
        if (operation == OP_START) begin
          edge_sec   = stamp_seconds;
          edge_us    = stamp_micros;
          mark_level = cfg.active_low;
        end else begin
          predict_edge(pin_level, stamp_seconds, stamp_micros);
        end
      end
    end
    backlog <= interval_q.size();
  end

endmodule

[bench/tb_ir_edge_pulse_space_recorder_core.sv]
// ---------------------------------------------------------------------------
// IR edge recorder core testbench
// Drives edge and start words with random gaps, stalls the receiver at
// random, walks through several register settings and leaves the checking
// to the interval checker. A watchdog ends a run that stops moving.
// ---------------------------------------------------------------------------
module tb_ir_edge_pulse_space_recorder_core;
  import ir_eps_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WORDS_PER_PHASE = 34;
  localparam int LAST_PHASE      = 6;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_BITS-1:0]     paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     operation = OP_EDGE;
  logic                     pin_level = 1'b0;
  logic [SEC_BITS-1:0]      stamp_seconds = '0;
  logic [US_BITS-1:0]       stamp_micros = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DURATION_BITS-1:0] duration;
  logic                     is_pulse;
  logic                     last;

  int pending;
  int errors;
  int compared;

  // sender bookkeeping
  logic [SEC_BITS-1:0] now_sec = '0;
  logic [US_BITS-1:0]  now_us = '0;
  logic                prev_pin = 1'b0;
  cfg_t                cur_cfg;
  int                  words_sent = 0;
  int                  starts_sent = 0;
  int                  settings_used = 1;
  bit                  burst_in = 1'b0;
  bit                  burst_out = 1'b0;
  bit                  hold_req = 1'b0;
  int                  quiet = 0;

  always #2 clk = ~clk;

  ir_edge_pulse_space_recorder_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .pin_level(pin_level), .stamp_seconds(stamp_seconds),
    .stamp_micros(stamp_micros),
    .out_valid(out_valid), .out_ready(out_ready), .duration(duration),
    .is_pulse(is_pulse), .last(last)
  );

  ir_eps_interval_checker i_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .pin_level(pin_level), .stamp_seconds(stamp_seconds),
    .stamp_micros(stamp_micros),
    .out_valid(out_valid), .out_ready(out_ready), .duration(duration),
    .is_pulse(is_pulse), .last(last),
    .pending(pending), .errors(errors), .compared(compared)
  );

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_ir_edge_pulse_space_recorder_core: errors");
        $finish;
      end
    end
  end

  // one register write: setup cycle, then access cycle
  task automatic reg_write(input reg_index_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for the core to run dry
  task automatic drain_core();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t c);
    drain_core();
    reg_write(REG_ACTIVE_LOW, 32'(c.active_low));
    reg_write(REG_PULSE_FLUSH_MIN, 32'(c.pulse_flush_min));
    reg_write(REG_GAP_HOLD_MIN, 32'(c.gap_hold_min));
    reg_write(REG_LONG_GAP_SECONDS, 32'(c.long_gap_seconds));
    cur_cfg = c;
    settings_used++;
  endtask

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input logic op, input logic pin,
                           input logic [SEC_BITS-1:0] sec,
                           input logic [US_BITS-1:0] us);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    pin_level     <= pin;
    stamp_seconds <= sec;
    stamp_micros  <= us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (op == OP_START) starts_sent++;
    now_sec  = sec;
    now_us   = us;
    prev_pin = pin;
  endtask

  // mostly well-formed edge trains, with some starts and noise
  task automatic random_word();
    int unsigned         kind;
    int unsigned         delta;
    int unsigned         total;
    logic [SEC_BITS-1:0] sec;
    logic [US_BITS-1:0]  us;
    logic                pin;
    kind  = $urandom_range(0, 99);
    pin   = ($urandom_range(0, 7) == 0) ? 1'($urandom) : ~prev_pin;
    sec   = now_sec;
    us    = now_us;
    delta = 0;
    if (kind < 40) begin
      delta = $urandom_range(0, 3000);
    end else if (kind < 55) begin
      delta = $urandom_range(3000, 60000);
    end else if (kind < 65) begin
      // just over the hold threshold where that is reachable
      if (cur_cfg.gap_hold_min < 24'd2000000)
        delta = cur_cfg.gap_hold_min + $urandom_range(1, 40000);
      else
        delta = $urandom_range(1, 100000);
    end else if (kind < 72) begin
      sec = now_sec + cur_cfg.long_gap_seconds + $urandom_range(1, 40);
    end else if (kind < 77) begin
      // clock ran backwards
      sec = now_sec - $urandom_range(1, 3);
      us  = US_BITS'($urandom_range(0, 999999));
    end else if (kind < 82) begin
      // span too long for the duration field, but not a long gap
      if (cur_cfg.long_gap_seconds > 16) begin
        sec = now_sec + $urandom_range(17, cur_cfg.long_gap_seconds);
        us  = US_BITS'($urandom_range(0, 999999));
      end else begin
        delta = $urandom_range(0, 3000);
      end
    end else if (kind < 90) begin
      if ($urandom_range(0, 3) == 0) begin
        send_word(OP_START, 1'($urandom), $urandom,
                  US_BITS'($urandom_range(0, 999999)));
      end else begin
        total = now_us + $urandom_range(0, 5000);
        send_word(OP_START, 1'($urandom), now_sec + total / 1000000,
                  US_BITS'(total % 1000000));
      end
      return;
    end else begin
      // noise
      if ($urandom_range(0, 9) == 0) us = US_BITS'($urandom);
      else us = US_BITS'($urandom_range(0, 999999));
      send_word(1'($urandom), 1'($urandom), $urandom, us);
      return;
    end
    total = us + delta;
    sec   = sec + total / 1000000;
    us    = US_BITS'(total % 1000000);
    send_word(OP_EDGE, pin, sec, us);
  endtask

  // receiver: random stalls, bursts, and one long hold-off
  initial begin
    int  stall;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = burst_out ? 0 : $urandom_range(0, 13);
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 16 == 0) burst_out = ($urandom_range(0, 2) == 0);
    end
  end

  // sender: reset, directed words, then random phases
  initial begin
    cfg_t c;
    cur_cfg.active_low       = RST_ACTIVE_LOW;
    cur_cfg.pulse_flush_min  = RST_PULSE_FLUSH_MIN;
    cur_cfg.gap_hold_min     = RST_GAP_HOLD_MIN;
    cur_cfg.long_gap_seconds = RST_LONG_GAP_SECONDS;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset settings
    send_word(OP_EDGE,  1'b1, 32'd0, 20'd0);        // edge before any start
    send_word(OP_EDGE,  1'b0, 32'd0, 20'd500);
    send_word(OP_START, 1'b0, 32'd10, 20'd0);
    send_word(OP_EDGE,  1'b1, 32'd10, 20'd300);
    send_word(OP_EDGE,  1'b0, 32'd10, 20'd30300);   // long space is held
    send_word(OP_EDGE,  1'b1, 32'd10, 20'd30400);
    send_word(OP_EDGE,  1'b0, 32'd10, 20'd60400);   // second long space merges
    send_word(OP_EDGE,  1'b1, 32'd10, 20'd60700);   // pulse sum flushes the pair
    send_word(OP_EDGE,  1'b0, 32'd10, 20'd90700);
    send_word(OP_EDGE,  1'b1, 32'd10, 20'd90800);
    send_word(OP_EDGE,  1'b0, 32'd10, 20'd91300);   // short space flushes three
    send_word(OP_EDGE,  1'b1, 32'd9, 20'd0);        // clock backwards
    send_word(OP_EDGE,  1'b1, 32'd25, 20'd0);       // long gap as pulse: polarity flips
    send_word(OP_EDGE,  1'b0, 32'd25, 20'd1000);
    send_word(OP_START, 1'b1, 32'd30, 20'hFFFFF);   // micros out of range
    send_word(OP_EDGE,  1'b0, 32'd31, 20'd0);       // negative span gives zero
    send_word(OP_EDGE,  1'b0, 32'd40, 20'd0);
    send_word(OP_EDGE,  1'b0, 32'd60, 20'd0);       // held space sum saturates
    send_word(OP_EDGE,  1'b1, 32'd60, 20'd200);
    send_word(OP_EDGE,  1'b1, 32'd60, 20'd200);
    send_word(OP_EDGE,  1'b1, 32'd60, 20'd300);
    send_word(OP_START, 1'b1, 32'hFFFF_FFFF, 20'd999999);
    send_word(OP_EDGE,  1'b0, 32'd0, 20'd0);
    send_word(OP_EDGE,  1'b1, 32'hFFFF_FFFF, 20'd999999);
    send_word(OP_EDGE,  1'b1, 32'hFFFF_FFFF, 20'd999999);

    // random phases, one register setting each
    for (int p = 0; p <= LAST_PHASE; p++) begin
      c = cur_cfg;
      case (p)
        1: begin
          c.active_low = 1'b0; c.pulse_flush_min = '0;
          c.gap_hold_min = '0; c.long_gap_seconds = LGS_BITS'(1);
        end
        2: begin
          c.active_low = 1'b1; c.pulse_flush_min = '1;
          c.gap_hold_min = '0; c.long_gap_seconds = '1;
        end
        3: begin
          c.active_low = 1'b0; c.pulse_flush_min = THR_BITS'($urandom_range(50, 2000));
          c.gap_hold_min = '1; c.long_gap_seconds = '1;
        end
        4: begin
          c.active_low = 1'b1; c.pulse_flush_min = THR_BITS'($urandom_range(50, 3000));
          c.gap_hold_min = THR_BITS'($urandom_range(1000, 50000));
          c.long_gap_seconds = LGS_BITS'($urandom_range(1, 63));
        end
        5: begin
          c.active_low = 1'($urandom); c.pulse_flush_min = THR_BITS'($urandom);
          c.gap_hold_min = THR_BITS'($urandom);
          c.long_gap_seconds = LGS_BITS'($urandom_range(1, 63));
        end
        6: begin
          c.active_low = RST_ACTIVE_LOW; c.pulse_flush_min = RST_PULSE_FLUSH_MIN;
          c.gap_hold_min = RST_GAP_HOLD_MIN; c.long_gap_seconds = RST_LONG_GAP_SECONDS;
        end
        default: ;
      endcase
      if (p != 0) load_setting(c);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (k % 10 == 0) burst_in = ($urandom_range(0, 3) == 0);
        // receiver holds off while the sender keeps offering
        if (p == 1 && k == 5) hold_req = 1'b1;
        if (p == 3 && k == 17) drain_core();
        random_word();
      end
    end

    drain_core();
    $display("covered %0d input words (%0d starts) over %0d register settings",
             words_sent, starts_sent, settings_used);
    $display("%0d result words compared, %0d failures", compared, errors);
    if (errors == 0) begin
      $display("tb_ir_edge_pulse_space_recorder_core: clean");
    end else begin
      $display("tb_ir_edge_pulse_space_recorder_core: errors");
    end
    $finish;
  end

endmodule
